// File: src/rshd_pkg.sv
// Package for the radial shell density histogram unit.
// Holds word structs, sizing constants and fixed-point constants; no dependencies.
package rshd_pkg;

    localparam int MAX_SHELLS = 64;
    localparam int COORD_W    = 32;
    localparam int SH_W       = $clog2(MAX_SHELLS);
    localparam int NSH_W      = $clog2(MAX_SHELLS + 1);
    localparam int ACC_W      = 130;

    // 4*pi/3 in Q.30 is 2^32 + VOL_K_LO
    localparam logic [31:0] VOL_K_LO = 32'd202711939;

    localparam logic [1:0] MODE_EDGE = 2'd0;
    localparam logic [1:0] MODE_PART = 2'd1;
    localparam logic [1:0] MODE_EMIT = 2'd2;

    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_SHELLS   = 3'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         shell_index;
        logic [31:0]        edge_radius;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               selected;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  shell_number;
        logic [31:0] particle_count;
        logic [63:0] density;
        logic        last;
    } t_out_word;

endpackage

// File: src/rshd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rshd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/radial_shell_density_histogram_unit.sv
// Particle: the squared distance is formed axis by axis, then each shell scanned
// takes an edge read, the shared 32x32 multiplier and a compare. Edge loads leave
// the unit idle. Emit: per shell in use, 10 multiplier steps for the volume and a
// 64-step restoring divide (skipped when the density saturates), plus output stall
// waits; o_stall stays high until the last shell's word is registered.
// Synchronous active-low reset clears control, centre config and count valid bits and sets the shell count to 64.
// Depends on rshd_pkg and rshd_ram.
module radial_shell_density_histogram_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rshd_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rshd_pkg::t_out_word o_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_RD   = 9'b000000100,
        S_EDGE = 9'b000001000,
        S_CMP  = 9'b000010000,
        S_VOL  = 9'b000100000,
        S_OVF  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_cx, r_cy, r_cz;
    logic [6:0]  r_shells;
    logic [rshd_pkg::NSH_W-1:0] shells_n;
    logic [rshd_pkg::SH_W-1:0]  last_j;

    logic r_emit;
    logic [rshd_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [rshd_pkg::SH_W-1:0] r_j;
    logic [3:0]  r_step;
    logic [63:0] r_d2, r_prod, r_sq;
    logic [31:0] r_edge, r_prev_edge, r_cnt;
    logic [95:0] r_diff, r_prev_cube;
    logic [rshd_pkg::ACC_W-1:0] r_acc, r_rem;
    logic [63:0] r_q;
    logic [5:0]  r_bit;
    logic [rshd_pkg::MAX_SHELLS-1:0] r_vld;
    logic        r_ovld;
    rshd_pkg::t_out_word r_out;

    logic [31:0] mul_a, mul_b;
    logic [31:0] edge_rd, cnt_rd, cnt_val;
    logic        in_acc, out_acc;
    logic        cnt_we;
    logic [31:0] cnt_wdata;
    logic        edge_we;

    logic [rshd_pkg::COORD_W-1:0] ax_p, ax_c;
    logic signed [rshd_pkg::COORD_W:0] ax_d;
    logic [rshd_pkg::COORD_W:0] ax_abs;
    logic [64:0] d2_sum;
    logic [rshd_pkg::ACC_W-1:0] div_t, cnt_sh;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovld && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovld;
    assign o_data  = r_out;

    always_comb begin
        if (r_shells == 7'd0) begin
            shells_n = rshd_pkg::NSH_W'(1);
        end else if (32'(r_shells) > rshd_pkg::MAX_SHELLS) begin
            shells_n = rshd_pkg::NSH_W'(rshd_pkg::MAX_SHELLS);
        end else begin
            shells_n = rshd_pkg::NSH_W'(r_shells);
        end
    end
    assign last_j = rshd_pkg::SH_W'(shells_n - rshd_pkg::NSH_W'(1));

    rshd_ram #(.WIDTH(32), .DEPTH(rshd_pkg::MAX_SHELLS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (i_data.shell_index[rshd_pkg::SH_W-1:0]),
        .i_wdata (i_data.edge_radius),
        .i_raddr (r_j),
        .o_rdata (edge_rd)
    );

    rshd_ram #(.WIDTH(32), .DEPTH(rshd_pkg::MAX_SHELLS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_j),
        .i_wdata (cnt_wdata),
        .i_raddr (r_j),
        .o_rdata (cnt_rd)
    );

    assign edge_we = in_acc && (i_data.mode == rshd_pkg::MODE_EDGE)
                     && (32'(i_data.shell_index) < rshd_pkg::MAX_SHELLS);
    assign cnt_val = r_vld[r_j] ? cnt_rd : 32'd0;
    assign cnt_we  = (r_state == S_CMP) && (r_d2 <= r_prod);
    assign cnt_wdata = (cnt_val == 32'hFFFF_FFFF) ? cnt_val : cnt_val + 32'd1;

    // axis select for squaring
    always_comb begin
        case (r_step[2:1])
            2'd0:    begin ax_p = r_px; ax_c = r_cx[rshd_pkg::COORD_W-1:0]; end
            2'd1:    begin ax_p = r_py; ax_c = r_cy[rshd_pkg::COORD_W-1:0]; end
            default: begin ax_p = r_pz; ax_c = r_cz[rshd_pkg::COORD_W-1:0]; end
        endcase
        ax_d   = $signed({ax_p[rshd_pkg::COORD_W-1], ax_p})
                 - $signed({ax_c[rshd_pkg::COORD_W-1], ax_c});
        ax_abs = ax_d[rshd_pkg::COORD_W] ? (rshd_pkg::COORD_W+1)'(-ax_d)
                                         : (rshd_pkg::COORD_W+1)'(ax_d);
    end

    assign d2_sum = {1'b0, r_d2} + {1'b0, r_prod};
    assign div_t  = {r_rem[rshd_pkg::ACC_W-2:0], 1'b0};
    assign cnt_sh = rshd_pkg::ACC_W'({r_cnt, 46'd0});

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_SQ: begin
                mul_a = 32'(ax_abs[rshd_pkg::COORD_W-1:0]);
                mul_b = 32'(ax_abs[rshd_pkg::COORD_W-1:0]);
            end
            S_EDGE: begin
                mul_a = edge_rd;
                mul_b = edge_rd;
            end
            S_VOL: begin
                case (r_step)
                    4'd0: begin mul_a = r_edge;        mul_b = r_edge; end
                    4'd2: begin mul_a = r_sq[31:0];    mul_b = r_edge; end
                    4'd3: begin mul_a = r_sq[63:32];   mul_b = r_edge; end
                    4'd6: begin mul_a = r_diff[31:0];  mul_b = rshd_pkg::VOL_K_LO; end
                    4'd7: begin mul_a = r_diff[63:32]; mul_b = rshd_pkg::VOL_K_LO; end
                    4'd8: begin mul_a = r_diff[95:64]; mul_b = rshd_pkg::VOL_K_LO; end
                    default: begin mul_a = 32'd0; mul_b = 32'd0; end
                endcase
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_data.mode == rshd_pkg::MODE_PART && i_data.selected) begin
                    n_state = S_SQ;
                end else if (in_acc && i_data.mode == rshd_pkg::MODE_EMIT) begin
                    n_state = S_RD;
                end
            end
            S_SQ:   if (r_step == 4'd6) n_state = S_RD;
            S_RD:   n_state = S_EDGE;
            S_EDGE: n_state = r_emit ? S_VOL : S_CMP;
            S_CMP: begin
                if (r_d2 <= r_prod || r_j == last_j) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_VOL:  if (r_step == 4'd9) n_state = S_OVF;
            S_OVF: begin
                if (r_edge <= r_prev_edge || cnt_sh >= r_acc) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  if (r_bit == 6'd0) n_state = S_OUT;
            S_OUT: begin
                if (!r_ovld || !i_stall) begin
                    n_state = (r_j == last_j) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cx     <= 32'd0;
            r_cy     <= 32'd0;
            r_cz     <= 32'd0;
            r_shells <= 7'd64;
            r_vld    <= '0;
            r_ovld   <= 1'b0;
            r_emit   <= 1'b0;
            r_j      <= '0;
            r_step   <= 4'd0;
            r_bit    <= 6'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rshd_pkg::CFG_CENTER_X: r_cx <= i_cfg_wdata;
                    rshd_pkg::CFG_CENTER_Y: r_cy <= i_cfg_wdata;
                    rshd_pkg::CFG_CENTER_Z: r_cz <= i_cfg_wdata;
                    rshd_pkg::CFG_SHELLS:   r_shells <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_ovld || !i_stall)) begin
                r_ovld <= 1'b1;
            end else if (out_acc) begin
                r_ovld <= 1'b0;
            end
            if (cnt_we) r_vld[r_j] <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    r_j    <= '0;
                    r_step <= 4'd0;
                    r_emit <= (i_data.mode == rshd_pkg::MODE_EMIT);
                end
                S_SQ:  r_step <= r_step + 4'd1;
                S_EDGE: r_step <= 4'd0;
                S_CMP: if (!(r_d2 <= r_prod) && r_j != last_j) r_j <= r_j + 1'b1;
                S_VOL: r_step <= r_step + 4'd1;
                S_OVF: r_bit <= 6'd63;
                S_DIV: r_bit <= r_bit - 6'd1;
                S_OUT: begin
                    if (!r_ovld || !i_stall) begin
                        if (r_j == last_j) begin
                            r_vld <= '0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (r_state)
            S_IDLE: begin
                r_px        <= i_data.pos_x[rshd_pkg::COORD_W-1:0];
                r_py        <= i_data.pos_y[rshd_pkg::COORD_W-1:0];
                r_pz        <= i_data.pos_z[rshd_pkg::COORD_W-1:0];
                r_d2        <= 64'd0;
                r_prev_edge <= 32'd0;
                r_prev_cube <= 96'd0;
            end
            S_SQ: begin
                if (r_step[0]) r_d2 <= d2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d2_sum[63:0];
            end
            S_EDGE: begin
                r_edge <= edge_rd;
                r_cnt  <= cnt_val;
            end
            S_VOL: begin
                case (r_step)
                    4'd1: r_sq  <= r_prod;
                    4'd3: r_acc <= rshd_pkg::ACC_W'(r_prod);
                    4'd4: r_acc <= r_acc + (rshd_pkg::ACC_W'(r_prod) << 32);
                    4'd5: begin
                        r_diff      <= r_acc[95:0] - r_prev_cube;
                        r_prev_cube <= r_acc[95:0];
                    end
                    4'd6: r_acc <= rshd_pkg::ACC_W'(r_diff) << 32;
                    4'd7: r_acc <= r_acc + rshd_pkg::ACC_W'(r_prod);
                    4'd8: r_acc <= r_acc + (rshd_pkg::ACC_W'(r_prod) << 32);
                    4'd9: r_acc <= r_acc + (rshd_pkg::ACC_W'(r_prod) << 64);
                    default: ;
                endcase
            end
            S_OVF: begin
                r_prev_edge <= r_edge;
                r_rem       <= cnt_sh;
                r_q         <= (r_edge <= r_prev_edge || cnt_sh >= r_acc)
                               ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
            end
            S_DIV: begin
                if (div_t >= r_acc) begin
                    r_rem <= div_t - r_acc;
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= div_t;
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end
            S_OUT: begin
                if (!r_ovld || !i_stall) begin
                    r_out.shell_number   <= 6'(r_j);
                    r_out.particle_count <= r_cnt;
                    r_out.density        <= r_q;
                    r_out.last           <= (r_j == last_j);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: src/rshd_checker.sv
// Port-level checks for the radial shell density histogram unit.
// Depends on rshd_pkg; bound to the top level below.
module rshd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input rshd_pkg::t_in_word  i_data,
    input logic                o_valid,
    input logic                i_stall,
    input rshd_pkg::t_out_word o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.mode == rshd_pkg::MODE_EMIT |=> o_stall)
        else $error("emit did not make the unit busy");

    a_edge_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.mode == rshd_pkg::MODE_EDGE |=> !o_stall)
        else $error("edge load kept the unit busy");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.particle_count == 32'd0 |->
            o_data.density == 64'd0 || o_data.density == 64'hFFFF_FFFF_FFFF_FFFF)
        else $error("empty shell with nonzero density");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("unit not idle after reset");

endmodule

bind radial_shell_density_histogram_unit rshd_checker u_rshd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// File: bench/radial_shell_density_histogram_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for radial_shell_density_histogram_unit: shell edge loads,
// particle binning and profile emits checked word by word against a local predictor.
// Depends on rshd_pkg and the unit under test.
module radial_shell_density_histogram_unit_tb;

    localparam logic [1:0] MODE_NOP      = 2'd3;
    localparam logic [2:0] CFG_UNUSED_LO = 3'd4;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam logic [63:0] VOL_K        = {32'd1, rshd_pkg::VOL_K_LO};
    localparam int SETTLE = 260;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    rshd_pkg::t_in_word  i_data;
    logic                o_valid;
    logic                i_stall;
    rshd_pkg::t_out_word o_data;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_addr;
    logic [31:0]         i_cfg_wdata;

    logic [31:0] ctr_x, ctr_y, ctr_z;
    logic [6:0]  shells_cfg;
    logic [31:0] edge_mem [rshd_pkg::MAX_SHELLS];
    logic [31:0] cnt_mem [rshd_pkg::MAX_SHELLS];
    rshd_pkg::t_out_word profile_q [$];
    int          errors;
    bit          calm;

    radial_shell_density_histogram_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [63:0] axis_sq(logic [31:0] p, logic [31:0] c);
        logic signed [32:0] d;
        logic [32:0] a;
        d = $signed({p[31], p}) - $signed({c[31], c});
        a = d[32] ? -d : d;
        if (a[32]) return '1;
        return 64'(a[31:0]) * 64'(a[31:0]);
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] shell_density(logic [31:0] cnt, logic [31:0] inner,
                                                  logic [31:0] outer);
        logic [191:0] o3, i3, den, num, q;
        o3 = 192'(outer);
        o3 = o3 * outer * outer;
        i3 = 192'(inner);
        i3 = i3 * inner * inner;
        if (o3 <= i3) return '1;
        den = (o3 - i3) * 192'(VOL_K);
        num = 192'(cnt) << 110;
        q = num / den;
        if (q[191:64] != 0) return '1;
        return q[63:0];
    endfunction

    function automatic int shells_active();
        if (shells_cfg == 0) return 1;
        if (shells_cfg > rshd_pkg::MAX_SHELLS) return rshd_pkg::MAX_SHELLS;
        return shells_cfg;
    endfunction

    task automatic predict_word(rshd_pkg::t_in_word w);
        int n;
        logic [63:0] d2, e;
        logic [31:0] inner;
        rshd_pkg::t_out_word r;
        n = shells_active();
        case (w.mode)
            rshd_pkg::MODE_EDGE: edge_mem[w.shell_index] = w.edge_radius;
            rshd_pkg::MODE_PART: begin
                if (w.selected) begin
                    d2 = sat_sum(sat_sum(axis_sq(w.pos_x, ctr_x), axis_sq(w.pos_y, ctr_y)),
                                 axis_sq(w.pos_z, ctr_z));
                    for (int j = 0; j < n; j++) begin
                        e = 64'(edge_mem[j]) * 64'(edge_mem[j]);
                        if (d2 <= e) begin
                            if (cnt_mem[j] != '1) cnt_mem[j]++;
                            break;
                        end
                    end
                end
            end
            rshd_pkg::MODE_EMIT: begin
                inner = 0;
                for (int j = 0; j < n; j++) begin
                    r.shell_number   = 6'(j);
                    r.particle_count = cnt_mem[j];
                    r.density        = shell_density(cnt_mem[j], inner, edge_mem[j]);
                    r.last           = (j + 1 == n);
                    profile_q = {profile_q, r};
                    inner = edge_mem[j];
                end
                foreach (cnt_mem[j]) cnt_mem[j] = 0;
            end
            default: ;
        endcase
    endtask

    // entered and left at a falling edge; valid stays high between back-to-back words
    task automatic send_word(rshd_pkg::t_in_word w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data  <= w;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_word(w);
        @(negedge i_clk);
    endtask

    function automatic rshd_pkg::t_in_word mk(logic [1:0] mode, logic [5:0] idx,
                                              logic [31:0] rad, logic [31:0] x,
                                              logic [31:0] y, logic [31:0] z, logic sel);
        rshd_pkg::t_in_word w;
        w.mode = mode; w.shell_index = idx; w.edge_radius = rad;
        w.pos_x = x; w.pos_y = y; w.pos_z = z; w.selected = sel;
        return w;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (profile_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            rshd_pkg::CFG_CENTER_X: ctr_x = data;
            rshd_pkg::CFG_CENTER_Y: ctr_y = data;
            rshd_pkg::CFG_CENTER_Z: ctr_z = data;
            rshd_pkg::CFG_SHELLS:   shells_cfg = data[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_profile(int n, logic [31:0] step);
        logic [31:0] e;
        e = $urandom_range(0, step);
        for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) != 0) e = e + $urandom_range(1, step);
            send_word(mk(rshd_pkg::MODE_EDGE, 6'(j), e, $urandom, $urandom, $urandom,
                         1'($urandom)));
        end
    endtask

    function automatic logic [31:0] near(logic [31:0] c, logic [31:0] r);
        return c + $urandom_range(0, 2 * r) - r;
    endfunction

    task automatic test_edge_table();
        for (int j = 0; j < rshd_pkg::MAX_SHELLS; j++)
            send_word(mk(rshd_pkg::MODE_EDGE, 6'(j),
                         (j == 0) ? 32'd1 : (j == 5) ? 32'h0001_8000 + 4 * 32'h8000
                         : (j == 63) ? 32'hFFFF_FFFF : 32'h0001_0000 + j * 32'h8000,
                         $urandom, $urandom, $urandom, 1'b0));
    endtask

    task automatic test_directed();
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, '0, '0, '0, 1'b1));
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, '0, '0, '0, 1'b1));
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, '0, 1'b1));
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h0002_0000, '0, '0, 1'b1));
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h0001_0000, 32'h0001_0000, '0, 1'b0));
        send_word(mk(MODE_NOP, 6'h3F, '1, '1, '1, '1, 1'b1));
        send_word(mk(rshd_pkg::MODE_EMIT, '0, '0, '0, '0, '0, 1'b0));
        drain();
        cfg_write(rshd_pkg::CFG_CENTER_X, 32'h8000_0000);
        cfg_write(rshd_pkg::CFG_CENTER_Y, 32'h7FFF_FFFF);
        cfg_write(rshd_pkg::CFG_CENTER_Z, 32'h8000_0000);
        cfg_write(rshd_pkg::CFG_SHELLS, 32'd127);
        cfg_write(CFG_UNUSED_LO, '1);
        cfg_write(CFG_UNUSED_HI, 32'd1);
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     1'b1));
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     1'b1));
        send_word(mk(rshd_pkg::MODE_EMIT, '0, '0, '0, '0, '0, 1'b1));
        drain();
        cfg_write(rshd_pkg::CFG_SHELLS, 32'd0);
        send_word(mk(rshd_pkg::MODE_PART, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     1'b1));
        send_word(mk(rshd_pkg::MODE_EMIT, '0, '0, '0, '0, '0, 1'b0));
        drain();
        cfg_write(rshd_pkg::CFG_SHELLS, 32'd1);
        send_word(mk(rshd_pkg::MODE_EMIT, '0, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic test_random_phase(int n_shells, int n_items, bit quiet, bit hold);
        logic [31:0] span;
        int r;
        drain();
        calm = quiet;
        cfg_write(rshd_pkg::CFG_CENTER_X, $urandom);
        cfg_write(rshd_pkg::CFG_CENTER_Y, $urandom);
        cfg_write(rshd_pkg::CFG_CENTER_Z, $urandom);
        cfg_write(rshd_pkg::CFG_SHELLS, 32'(n_shells));
        span = $urandom_range(32'h100, 32'h0004_0000);
        load_profile(shells_active(), span);
        for (int i = 0; i < n_items; i++) begin
            if (hold && i == n_items / 2) begin
                i_valid <= 1'b0;
                while (profile_q.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                send_word(mk(rshd_pkg::MODE_EMIT, 6'($urandom), $urandom, $urandom, $urandom,
                             $urandom, 1'($urandom)));
            else if (r < 9)
                send_word(mk(rshd_pkg::MODE_EDGE, 6'($urandom_range(0, shells_active() - 1)),
                             $urandom, $urandom, $urandom, $urandom, 1'($urandom)));
            else if (r < 16)
                send_word(mk($urandom_range(0, 1) ? MODE_NOP : rshd_pkg::MODE_PART,
                             6'($urandom), $urandom, $urandom, $urandom, $urandom,
                             1'($urandom)));
            else
                send_word(mk(rshd_pkg::MODE_PART, 6'($urandom), $urandom,
                             near(ctr_x, edge_mem[shells_active() - 1]),
                             near(ctr_y, edge_mem[shells_active() - 1]),
                             near(ctr_z, edge_mem[shells_active() - 1]),
                             $urandom_range(0, 7) != 0));
        end
        send_word(mk(rshd_pkg::MODE_EMIT, '0, '0, '0, '0, '0, 1'b1));
        calm = 1'b0;
    endtask

    // receiver: random stall before each accepted word
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            n = draw_gap();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        rshd_pkg::t_out_word e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (profile_q.size() == 0) begin
                $error("unexpected word shell_number %0d", o_data.shell_number);
                errors++;
            end else begin
                e = profile_q.pop_front();
                if (o_data.shell_number !== e.shell_number) begin
                    $error("shell_number expected %0d actual %0d", e.shell_number,
                           o_data.shell_number);
                    errors++;
                end
                if (o_data.particle_count !== e.particle_count) begin
                    $error("particle_count expected %0d actual %0d", e.particle_count,
                           o_data.particle_count);
                    errors++;
                end
                if (o_data.density !== e.density) begin
                    $error("density expected %h actual %h", e.density, o_data.density);
                    errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_data.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors      = 0;
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = rshd_pkg::CFG_CENTER_X;
        i_cfg_wdata = '0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0;
        shells_cfg = 7'd64;
        foreach (edge_mem[j]) begin
            edge_mem[j] = 0;
            cnt_mem[j]  = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_edge_table();
        test_directed();
        test_random_phase(6, 25, 1'b0, 1'b0);
        test_random_phase(1, 15, 1'b1, 1'b0);
        test_random_phase(12, 30, 1'b0, 1'b1);
        test_random_phase(3, 20, 1'b0, 1'b0);
        test_random_phase(16, 10, 1'b0, 1'b0);
        drain();
        if (errors == 0 && profile_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: radial_shell_density_histogram_unit.f
src/rshd_pkg.sv
src/rshd_ram.sv
src/radial_shell_density_histogram_unit.sv
src/rshd_checker.sv
bench/radial_shell_density_histogram_unit_tb.sv
